// ----- hdl/tarc_pkg.sv -----
// Shared types, constants and the octant lookup table for the table arctangent block.
package tarc_pkg;

    localparam int QUO_BITS  = 6;
    localparam int HEAD_BITS = 7;
    localparam int OCT_BITS  = 4;

    localparam logic [HEAD_BITS-1:0] HEADING_NONE    = 7'd64;
    localparam logic [HEAD_BITS-1:0] STEPS_FULL      = 7'd64;
    localparam logic [HEAD_BITS-1:0] STEPS_HALF      = 7'd32;
    localparam logic [HEAD_BITS-1:0] STEPS_QUARTER   = 7'd16;

    typedef logic [QUO_BITS-1:0]  quo_t;
    typedef logic [OCT_BITS-1:0]  oct_t;
    typedef logic [HEAD_BITS-1:0] head_t;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic swapped;
        logic y_zero;
        logic zero;
    } side_t;

    // Octant angle for a rounded ratio index; indexes from 30 upward map to the last entry.
    function automatic oct_t octant_lookup(input quo_t idx);
        oct_t val;
        case (idx) inside
            [6'd0:6'd1]:   val = 4'd0;
            [6'd2:6'd4]:   val = 4'd1;
            [6'd5:6'd8]:   val = 4'd2;
            [6'd9:6'd11]:  val = 4'd3;
            [6'd12:6'd15]: val = 4'd4;
            [6'd16:6'd19]: val = 4'd5;
            [6'd20:6'd23]: val = 4'd6;
            [6'd24:6'd29]: val = 4'd7;
            default:       val = 4'd8;
        endcase
        return val;
    endfunction

endpackage

// ----- hdl/tarc_vec_if.sv -----
// Channel interface that carries one input vector per transaction.
interface tarc_vec_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] delta_x;
    logic signed [COORD_BITS-1:0] delta_y;

    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

// ----- hdl/tarc_head_if.sv -----
// Channel interface that carries one heading per transaction.
interface tarc_head_if;
    logic                          valid;
    logic                          ready;
    logic [tarc_pkg::HEAD_BITS-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

// ----- hdl/tarc_prep.sv -----
// Front stage: magnitudes, ordering of the two components and the rounded dividend.
module tarc_prep #(
    parameter int COORD_BITS = 16,
    parameter int REM_W      = COORD_BITS + 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    tarc_vec_if.sink                sample,
    output logic                    down_valid,
    input  logic                    down_ready,
    output logic [REM_W-1:0]        rem_out,
    output logic [COORD_BITS-1:0]   big_out,
    output tarc_pkg::side_t         side_out
);
    import tarc_pkg::*;

    logic [COORD_BITS-1:0] raw_x;
    logic [COORD_BITS-1:0] raw_y;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [COORD_BITS-1:0] small_mag;
    logic [COORD_BITS-1:0] big_mag;
    logic                  take;
    logic                  valid_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [COORD_BITS-1:0] big_reg;
    side_t                 side_reg;
    side_t                 side_next;

    assign raw_x = sample.delta_x;
    assign raw_y = sample.delta_y;

    always_comb
    begin
        mag_x = raw_x[COORD_BITS-1] ? (~raw_x + COORD_BITS'(1)) : raw_x;
        mag_y = raw_y[COORD_BITS-1] ? (~raw_y + COORD_BITS'(1)) : raw_y;
        side_next.x_neg   = raw_x[COORD_BITS-1];
        side_next.y_neg   = raw_y[COORD_BITS-1];
        side_next.swapped = mag_x > mag_y;
        side_next.y_zero  = mag_y == '0;
        side_next.zero    = (mag_x == '0) && (mag_y == '0);
        small_mag = side_next.swapped ? mag_y : mag_x;
        big_mag   = side_next.swapped ? mag_x : mag_y;
        rem_next  = (REM_W'(small_mag) << (QUO_BITS - 1)) + REM_W'(big_mag[COORD_BITS-1:1]);
    end

    assign sample.ready = !valid_reg || down_ready;
    assign take         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rem_reg  <= rem_next;
            big_reg  <= big_mag;
            side_reg <= side_next;
        end
    end

    assign down_valid = valid_reg;
    assign rem_out    = rem_reg;
    assign big_out    = big_reg;
    assign side_out   = side_reg;

endmodule

// ----- hdl/tarc_div_cell.sv -----
// One restoring division cell that settles a single quotient bit.
module tarc_div_cell #(
    parameter int COORD_BITS = 16,
    parameter int REM_W      = COORD_BITS + 6,
    parameter int SHIFT      = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  logic [REM_W-1:0]        rem_in,
    input  tarc_pkg::quo_t          quo_in,
    input  logic [COORD_BITS-1:0]   big_in,
    input  tarc_pkg::side_t         side_in,
    output logic                    down_valid,
    input  logic                    down_ready,
    output logic [REM_W-1:0]        rem_out,
    output tarc_pkg::quo_t          quo_out,
    output logic [COORD_BITS-1:0]   big_out,
    output tarc_pkg::side_t         side_out
);
    import tarc_pkg::*;

    localparam quo_t BIT_MASK = QUO_BITS'(1) << SHIFT;
    localparam quo_t LOW_MASK = QUO_BITS'((1 << SHIFT) - 1);

    logic [REM_W-1:0]      divisor;
    logic                  fits;
    logic                  take;
    logic                  valid_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    quo_t                  quo_reg;
    quo_t                  quo_next;
    logic [COORD_BITS-1:0] big_reg;
    side_t                 side_reg;

    always_comb
    begin
        divisor  = REM_W'(big_in) << SHIFT;
        fits     = rem_in >= divisor;
        rem_next = fits ? (rem_in - divisor) : rem_in;
        quo_next = fits ? (quo_in | BIT_MASK) : quo_in;
    end

    assign up_ready = !valid_reg || down_ready;
    assign take     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            big_reg  <= big_in;
            side_reg <= side_in;
        end
    end

    assign down_valid = valid_reg;
    assign rem_out    = rem_reg;
    assign quo_out    = quo_reg;
    assign big_out    = big_reg;
    assign side_out   = side_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (big_reg != '0) |-> rem_reg < (REM_W'(big_reg) << SHIFT))
        else $error("remainder left a cell at or above its divisor");

    a_low_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (big_reg != '0) |-> (quo_reg & LOW_MASK) == '0)
        else $error("quotient bit below this cell set too early");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !down_ready |=> valid_reg && $stable(quo_reg) && $stable(rem_reg))
        else $error("cell dropped or changed a stalled transaction");
`endif

endmodule

// ----- hdl/tarc_fold.sv -----
// Back stage: octant table lookup, folding by component order and signs, and the output register.
module tarc_fold (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  tarc_pkg::quo_t  quo_in,
    input  tarc_pkg::side_t side_in,
    tarc_head_if.source     result
);
    import tarc_pkg::*;

    oct_t  oct;
    head_t ang_base;
    head_t ang_x;
    head_t ang_y;
    head_t heading_next;
    head_t heading_reg;
    logic  valid_reg;
    logic  take;

    always_comb
    begin
        oct          = octant_lookup(quo_in);
        ang_base     = side_in.swapped ? (STEPS_QUARTER - HEAD_BITS'(oct)) : HEAD_BITS'(oct);
        ang_x        = side_in.x_neg ? (STEPS_FULL - ang_base) : ang_base;
        ang_y        = (!side_in.y_neg && !side_in.y_zero) ? (STEPS_HALF - ang_x) : ang_x;
        heading_next = side_in.zero ? HEADING_NONE : {1'b0, ang_y[HEAD_BITS-2:0]};
    end

    assign up_ready = !valid_reg || result.ready;
    assign take     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            heading_reg <= heading_next;
        end
    end

    assign result.valid   = valid_reg;
    assign result.heading = heading_reg;

endmodule

// ----- hdl/table_arctan_angle.sv -----
// Top level of the table arctangent block: front stage, division cell chain and fold stage.
// One front stage, six division cells (one quotient bit each) and one fold stage.
// Throughput is one transaction per cycle unless result.ready holds the flow; each stage
// takes a new item while its own is taken.
// Reset clears only the valid bits of the stages; the data registers are not reset.
module table_arctan_angle #(
    parameter int COORD_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tarc_vec_if.sink   sample,
    tarc_head_if.source result
);
    import tarc_pkg::*;

    localparam int REM_W = COORD_BITS + QUO_BITS;

    logic                  valid_w [0:QUO_BITS];
    logic                  ready_w [0:QUO_BITS];
    logic [REM_W-1:0]      rem_w   [0:QUO_BITS];
    quo_t                  quo_w   [0:QUO_BITS];
    logic [COORD_BITS-1:0] big_w   [0:QUO_BITS];
    side_t                 side_w  [0:QUO_BITS];

    assign quo_w[0] = '0;

    tarc_prep #(
        .COORD_BITS (COORD_BITS),
        .REM_W      (REM_W)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .down_valid (valid_w[0]),
        .down_ready (ready_w[0]),
        .rem_out    (rem_w[0]),
        .big_out    (big_w[0]),
        .side_out   (side_w[0])
    );

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_cell
        tarc_div_cell #(
            .COORD_BITS (COORD_BITS),
            .REM_W      (REM_W),
            .SHIFT      (QUO_BITS - 1 - k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (valid_w[k]),
            .up_ready   (ready_w[k]),
            .rem_in     (rem_w[k]),
            .quo_in     (quo_w[k]),
            .big_in     (big_w[k]),
            .side_in    (side_w[k]),
            .down_valid (valid_w[k+1]),
            .down_ready (ready_w[k+1]),
            .rem_out    (rem_w[k+1]),
            .quo_out    (quo_w[k+1]),
            .big_out    (big_w[k+1]),
            .side_out   (side_w[k+1])
        );
    end

    tarc_fold u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (valid_w[QUO_BITS]),
        .up_ready (ready_w[QUO_BITS]),
        .quo_in   (quo_w[QUO_BITS]),
        .side_in  (side_w[QUO_BITS]),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[QUO_BITS] && (big_w[QUO_BITS] != '0)
        |-> rem_w[QUO_BITS] < REM_W'(big_w[QUO_BITS]))
        else $error("division chain left a remainder not below the divisor");

    a_zero_matches_big: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[0] |-> (side_w[0].zero == (big_w[0] == '0)))
        else $error("zero vector flag disagrees with the larger magnitude");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.heading <= HEADING_NONE)
        else $error("heading out of range");
`endif

endmodule
